// File: hdl/hns_pkg.sv
package hns_pkg;

    typedef struct packed {
        logic signed [16:0] diff_a;
        logic signed [16:0] diff_b;
        logic [15:0]        span;
        logic [9:0]         row;
        logic [9:0]         col;
    } qent_t;

    typedef enum logic [1:0] {
        F_IDLE,
        F_DATA,
        F_WR2
    } front_state_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_SQ,
        B_ROOT,
        B_DIV,
        B_DONE
    } back_state_t;

    localparam logic [0:0] REG_ROW_LENGTH = 1'b0;
    localparam logic [0:0] REG_GRID_SPAN  = 1'b1;

    localparam logic [10:0] ROW_LENGTH_RESET = 11'd256;
    localparam logic [15:0] GRID_SPAN_RESET  = 16'd1028;

endpackage

// File: hdl/hns_ram.sv
module hns_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: hdl/hns_front.sv
module hns_front #(
    parameter int MAX_ROW_LENGTH = 1024
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  logic [15:0]   height,
    input  logic          frame_start,
    input  logic [10:0]   row_length,
    input  logic [15:0]   grid_span,
    input  logic          q_full,
    output logic          push,
    output hns_pkg::qent_t push_data
);
    import hns_pkg::*;

    localparam int CW = $clog2(MAX_ROW_LENGTH);
    localparam int LW = CW + 1;
    localparam int XW = (LW > 11) ? LW : 11;
    localparam int RW = (CW > 10) ? CW : 10;

    front_state_t state_reg, state_next;

    logic [CW-1:0] row_reg, row_next;
    logic [CW-1:0] col_reg, col_next;
    logic [15:0]   tap0_reg, tap1_reg, prev_reg;
    logic [15:0]   h_reg, above_reg;
    logic [CW-1:0] r_reg, c_reg;
    logic          last_reg;

    logic [XW-1:0] rl_x, len_x;
    logic [LW-1:0] len;
    logic [LW-1:0] c_t, r_t, c1, r1;
    logic          accept;

    logic [15:0]   lp_rd, lp2_rd;
    logic          lp2_we;
    logic [CW-1:0] lp2_waddr;
    logic [15:0]   lp2_wdata;
    logic [RW-1:0] r_m1, c_m1;

    assign rl_x  = XW'(row_length);
    assign len_x = (rl_x < XW'(3)) ? XW'(3) :
                   ((rl_x > XW'(MAX_ROW_LENGTH)) ? XW'(MAX_ROW_LENGTH) : rl_x);
    assign len   = LW'(len_x);

    assign in_ready = (state_reg == F_IDLE) && !q_full;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        c_t = frame_start ? '0 : {1'b0, col_reg};
        r_t = frame_start ? '0 : {1'b0, row_reg};
        if (c_t >= len)
        begin
            c_t = '0;
            r_t = r_t + LW'(1);
        end
        if (r_t >= len)
        begin
            r_t = '0;
        end
        c1 = c_t + LW'(1);
        r1 = r_t + LW'(1);
        if (c1 >= len)
        begin
            col_next = '0;
            row_next = (r1 >= len) ? '0 : r1[CW-1:0];
        end
        else
        begin
            col_next = c1[CW-1:0];
            row_next = r_t[CW-1:0];
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            F_IDLE:
            begin
                if (accept)
                begin
                    state_next = F_DATA;
                end
            end
            F_DATA:
            begin
                state_next = last_reg ? F_WR2 : F_IDLE;
            end
            F_WR2:
            begin
                state_next = F_IDLE;
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_comb
    begin
        lp2_we    = 1'b0;
        lp2_waddr = c_reg - CW'(1);
        lp2_wdata = tap0_reg;
        case (state_reg)
            F_DATA:
            begin
                lp2_we = (c_reg != '0);
            end
            F_WR2:
            begin
                lp2_we    = 1'b1;
                lp2_waddr = c_reg;
                lp2_wdata = above_reg;
            end
            default:
            begin
                lp2_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            row_reg   <= '0;
            col_reg   <= '0;
            tap0_reg  <= '0;
            tap1_reg  <= '0;
            prev_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (accept)
            begin
                row_reg <= row_next;
                col_reg <= col_next;
            end
            if (state_reg == F_DATA)
            begin
                tap1_reg <= tap0_reg;
                tap0_reg <= lp_rd;
                prev_reg <= h_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            h_reg    <= height;
            r_reg    <= r_t[CW-1:0];
            c_reg    <= c_t[CW-1:0];
            last_reg <= (c_t == (len - LW'(1)));
        end
        if (state_reg == F_DATA)
        begin
            above_reg <= lp_rd;
        end
    end

    assign r_m1 = RW'(r_reg) - RW'(1);
    assign c_m1 = RW'(c_reg) - RW'(1);

    assign push = (state_reg == F_DATA) && (r_reg >= CW'(2)) && (c_reg >= CW'(2));
    assign push_data.diff_a = $signed({1'b0, prev_reg}) - $signed({1'b0, lp2_rd});
    assign push_data.diff_b = $signed({1'b0, lp_rd}) - $signed({1'b0, tap1_reg});
    assign push_data.span   = (grid_span == '0) ? 16'd1 : grid_span;
    assign push_data.row    = r_m1[9:0];
    assign push_data.col    = c_m1[9:0];

    hns_ram #(
        .WIDTH (16),
        .DEPTH (MAX_ROW_LENGTH)
    ) u_line_prev (
        .clk   (clk),
        .we    (state_reg == F_DATA),
        .waddr (c_reg),
        .wdata (h_reg),
        .raddr (c_t[CW-1:0]),
        .rdata (lp_rd)
    );

    hns_ram #(
        .WIDTH (16),
        .DEPTH (MAX_ROW_LENGTH)
    ) u_line_prev2 (
        .clk   (clk),
        .we    (lp2_we),
        .waddr (lp2_waddr),
        .wdata (lp2_wdata),
        .raddr (c_t[CW-1:0] - CW'(1)),
        .rdata (lp2_rd)
    );

endmodule

// File: hdl/hns_queue.sv
module hns_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  hns_pkg::qent_t push_data,
    output logic           full,
    input  logic           pop,
    output logic           q_valid,
    output hns_pkg::qent_t q_data
);
    import hns_pkg::*;

    qent_t      ent_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;

    assign full    = (cnt_reg == 2'd2);
    assign q_valid = (cnt_reg != 2'd0);
    assign q_data  = ent_reg[rp_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wp_reg <= ~wp_reg;
            end
            if (pop)
            begin
                rp_reg <= ~rp_reg;
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            ent_reg[wp_reg] <= push_data;
        end
    end

endmodule

// File: hdl/hns_back.sv
module hns_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_valid,
    input  hns_pkg::qent_t     q_data,
    output logic               pop,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [15:0] normal_x,
    output logic [14:0]        normal_y,
    output logic signed [15:0] normal_z,
    output logic [9:0]         center_row,
    output logic [9:0]         center_col
);
    import hns_pkg::*;

    back_state_t state_reg, state_next;

    qent_t              ent_reg;
    logic [4:0]         k_reg;
    logic [1:0]         which_reg;
    logic signed [33:0] prod_reg;
    logic [35:0]        acc_reg;
    logic [63:0]        x_reg;
    logic [35:0]        rem_reg;
    logic [31:0]        root_reg;
    logic [47:0]        num_reg;
    logic [47:0]        dsh_reg;
    logic [15:0]        q_reg;
    logic [15:0]        na_reg, ns_reg, nb_reg;
    logic               ov_reg;

    logic signed [16:0] mul_op;
    logic [35:0]        rem_sh, trial;
    logic               rge, dge;
    logic [15:0]        mag;
    logic [15:0]        qfin;
    logic               load_out;
    logic [15:0]        nx_sat, nz_sat;

    assign pop       = (state_reg == B_IDLE) && q_valid;
    assign load_out  = (state_reg == B_DONE) && (!ov_reg || out_ready);
    assign out_valid = ov_reg;

    always_comb
    begin
        case (k_reg[1:0])
            2'd0:    mul_op = ent_reg.diff_a;
            2'd1:    mul_op = $signed({1'b0, ent_reg.span});
            default: mul_op = ent_reg.diff_b;
        endcase
    end

    assign rem_sh = {rem_reg[33:0], x_reg[63:62]};
    assign trial  = {2'b00, root_reg, 2'b01};
    assign rge    = (rem_sh >= trial);
    assign dge    = (num_reg >= dsh_reg);
    assign qfin   = {q_reg[14:0], dge};

    always_comb
    begin
        case (which_reg)
            2'd0:    mag = ent_reg.diff_a[16] ? 16'(-ent_reg.diff_a) : ent_reg.diff_a[15:0];
            2'd1:    mag = ent_reg.span;
            default: mag = ent_reg.diff_b[16] ? 16'(-ent_reg.diff_b) : ent_reg.diff_b[15:0];
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            B_IDLE:
            begin
                if (q_valid)
                begin
                    state_next = B_SQ;
                end
            end
            B_SQ:
            begin
                if (k_reg == 5'd3)
                begin
                    state_next = B_ROOT;
                end
            end
            B_ROOT:
            begin
                if (k_reg == 5'd31)
                begin
                    state_next = B_DIV;
                end
            end
            B_DIV:
            begin
                if (k_reg == 5'd0 && which_reg == 2'd2)
                begin
                    state_next = B_DONE;
                end
            end
            B_DONE:
            begin
                if (load_out)
                begin
                    state_next = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_IDLE;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (load_out)
            begin
                ov_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                ov_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            B_IDLE:
            begin
                ent_reg <= q_data;
                k_reg   <= 5'd0;
                acc_reg <= '0;
            end
            B_SQ:
            begin
                prod_reg <= mul_op * mul_op;
                if (k_reg != 5'd0)
                begin
                    acc_reg <= acc_reg + 36'(unsigned'(prod_reg));
                end
                if (k_reg == 5'd3)
                begin
                    x_reg    <= {acc_reg + 36'(unsigned'(prod_reg)), 28'd0};
                    rem_reg  <= '0;
                    root_reg <= '0;
                    k_reg    <= 5'd0;
                end
                else
                begin
                    k_reg <= k_reg + 5'd1;
                end
            end
            B_ROOT:
            begin
                rem_reg  <= rge ? (rem_sh - trial) : rem_sh;
                root_reg <= {root_reg[30:0], rge};
                x_reg    <= {x_reg[61:0], 2'b00};
                if (k_reg == 5'd31)
                begin
                    k_reg     <= 5'd16;
                    which_reg <= 2'd0;
                end
                else
                begin
                    k_reg <= k_reg + 5'd1;
                end
            end
            B_DIV:
            begin
                if (k_reg == 5'd16)
                begin
                    num_reg <= {2'b00, mag, 30'd0} + 48'(root_reg);
                    dsh_reg <= {root_reg, 1'b0, 15'd0};
                    q_reg   <= '0;
                    k_reg   <= 5'd15;
                end
                else
                begin
                    if (dge)
                    begin
                        num_reg <= num_reg - dsh_reg;
                    end
                    dsh_reg <= {1'b0, dsh_reg[47:1]};
                    q_reg   <= qfin;
                    if (k_reg == 5'd0)
                    begin
                        case (which_reg)
                            2'd0:    na_reg <= qfin;
                            2'd1:    ns_reg <= qfin;
                            default: nb_reg <= qfin;
                        endcase
                        which_reg <= which_reg + 2'd1;
                        k_reg     <= 5'd16;
                    end
                    else
                    begin
                        k_reg <= k_reg - 5'd1;
                    end
                end
            end
            default:
            begin
                k_reg <= k_reg;
            end
        endcase
    end

    always_comb
    begin
        if (!ent_reg.diff_a[16] && ent_reg.diff_a != '0)
        begin
            nx_sat = 16'd0 - ((na_reg > 16'd32768) ? 16'd32768 : na_reg);
        end
        else
        begin
            nx_sat = (na_reg > 16'd32767) ? 16'd32767 : na_reg;
        end
        if (!ent_reg.diff_b[16] && ent_reg.diff_b != '0)
        begin
            nz_sat = 16'd0 - ((nb_reg > 16'd32768) ? 16'd32768 : nb_reg);
        end
        else
        begin
            nz_sat = (nb_reg > 16'd32767) ? 16'd32767 : nb_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            normal_x   <= $signed(nx_sat);
            normal_y   <= (ns_reg > 16'd32767) ? 15'd32767 : ns_reg[14:0];
            normal_z   <= $signed(nz_sat);
            center_row <= ent_reg.row;
            center_col <= ent_reg.col;
        end
    end

endmodule

// File: hdl/heightmap_normal_stencil.sv
// Channel   Handshake            Beat contents
// cfg       psel/penable/pready  paddr, pwdata, prdata (row_length, grid_span)
// in        in_valid/in_ready    height, frame_start
// out       out_valid/out_ready  normal_x, normal_y, normal_z, center_row, center_col
//
// The front takes a sample when idle, writes it in a data state, and adds a write at row end.
// A normal holds the back through a pop, three squares on one multiplier, 32 root steps,
// three 16-step divisions and an output load; a held output stalls it further.
// A two-entry queue between front and back lets each stall on its own.
// rst_n clears the counters and taps at once; the line stores need no clearing.
module heightmap_normal_stencil #(
    parameter int MAX_ROW_LENGTH = 1024
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [15:0]        height,
    input  logic               frame_start,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [15:0] normal_x,
    output logic [14:0]        normal_y,
    output logic signed [15:0] normal_z,
    output logic [9:0]         center_row,
    output logic [9:0]         center_col
);
    import hns_pkg::*;

    logic [10:0] row_length_reg;
    logic [15:0] grid_span_reg;
    logic        q_full, push, pop, q_valid;
    qent_t       push_data, q_data;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_GRID_SPAN) ? {16'd0, grid_span_reg}
                                                : {21'd0, row_length_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_length_reg <= ROW_LENGTH_RESET;
            grid_span_reg  <= GRID_SPAN_RESET;
        end
        else if (psel && penable && pwrite)
        begin
            if (paddr[2] == REG_ROW_LENGTH)
            begin
                row_length_reg <= pwdata[10:0];
            end
            else
            begin
                grid_span_reg <= pwdata[15:0];
            end
        end
    end

    hns_front #(
        .MAX_ROW_LENGTH (MAX_ROW_LENGTH)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .height      (height),
        .frame_start (frame_start),
        .row_length  (row_length_reg),
        .grid_span   (grid_span_reg),
        .q_full      (q_full),
        .push        (push),
        .push_data   (push_data)
    );

    hns_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (q_full),
        .pop       (pop),
        .q_valid   (q_valid),
        .q_data    (q_data)
    );

    hns_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_valid),
        .q_data     (q_data),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .normal_x   (normal_x),
        .normal_y   (normal_y),
        .normal_z   (normal_z),
        .center_row (center_row),
        .center_col (center_col)
    );

endmodule

// File: tb/heightmap_normal_stencil_tb.sv
module heightmap_normal_stencil_tb;
    import hns_pkg::*;

    typedef struct packed {
        logic signed [15:0] nx;
        logic [14:0]        ny;
        logic signed [15:0] nz;
        logic [9:0]         row;
        logic [9:0]         col;
    } normal_t;

    typedef struct {
        logic [15:0] h;
        logic        fs;
        bit          typed;
        normal_t     want;
    } sample_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [2:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;
    logic in_valid = 1'b0;
    logic in_ready;
    logic [15:0] height = '0;
    logic frame_start = 1'b0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic signed [15:0] normal_x;
    logic [14:0] normal_y;
    logic signed [15:0] normal_z;
    logic [9:0] center_row;
    logic [9:0] center_col;

    heightmap_normal_stencil u_top (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .in_valid(in_valid), .in_ready(in_ready),
        .height(height), .frame_start(frame_start),
        .out_valid(out_valid), .out_ready(out_ready),
        .normal_x(normal_x), .normal_y(normal_y), .normal_z(normal_z),
        .center_row(center_row), .center_col(center_col)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    int          row_len_reg = ROW_LENGTH_RESET;
    int          span_reg = GRID_SPAN_RESET;
    logic [15:0] store_above [0:1023];
    logic [15:0] store_two_up [0:1023];
    logic [15:0] left_sample = '0;
    logic [15:0] tap0 = '0;
    logic [15:0] tap1 = '0;
    int          row_cnt = 0;
    int          col_cnt = 0;

    normal_t     pending_normals[$];
    sample_row_t directed_rows[$];
    bit          failed = 1'b0;
    bit          quiet = 1'b0;
    int          beats_seen = 0;

    function automatic bit [63:0] int_sqrt(bit [63:0] x);
        bit [63:0] res = 0;
        bit [63:0] b = 64'd1 << 62;
        while (b > x)
            b >>= 2;
        while (b != 0)
        begin
            if (x >= res + b)
            begin
                x -= res + b;
                res = (res >> 1) + b;
            end
            else
                res >>= 1;
            b >>= 2;
        end
        return res;
    endfunction

    function automatic bit [63:0] unit_mag(bit [63:0] mag, bit [63:0] rt);
        return ((mag << 30) + rt) / (2 * rt);
    endfunction

    function automatic logic [15:0] neg_comp(longint v, bit [63:0] rt);
        bit [63:0] n;
        n = unit_mag(v < 0 ? -v : v, rt);
        if (v > 0)
        begin
            if (n > 32768)
                n = 32768;
            return 16'(65536 - n);
        end
        if (n > 32767)
            n = 32767;
        return n[15:0];
    endfunction

    task automatic predict_normal(input logic [15:0] h, input logic fs,
                                  output bit hit, output normal_t res);
        int          len;
        int          r;
        int          c;
        logic [15:0] above;
        longint      a;
        longint      b;
        longint      s;
        bit [63:0]   rt;
        bit [63:0]   ny;
        len = row_len_reg < 3 ? 3 : (row_len_reg > 1024 ? 1024 : row_len_reg);
        hit = 1'b0;
        res = '0;
        if (fs)
        begin
            row_cnt = 0;
            col_cnt = 0;
        end
        if (col_cnt >= len)
        begin
            col_cnt = 0;
            row_cnt++;
        end
        if (row_cnt >= len)
            row_cnt = 0;
        r = row_cnt;
        c = col_cnt;
        above = store_above[c];
        if (r >= 2 && c >= 2)
        begin
            a = longint'(left_sample) - longint'(store_two_up[c - 1]);
            b = longint'(above) - longint'(tap1);
            s = span_reg == 0 ? 1 : span_reg;
            rt = int_sqrt(64'(a * a + s * s + b * b) << 28);
            ny = unit_mag(s, rt);
            if (ny > 32767)
                ny = 32767;
            res.nx = neg_comp(a, rt);
            res.ny = ny[14:0];
            res.nz = neg_comp(b, rt);
            res.row = 10'(r - 1);
            res.col = 10'(c - 1);
            hit = 1'b1;
        end
        if (c >= 1)
            store_two_up[c - 1] = tap0;
        if (c == len - 1)
            store_two_up[c] = above;
        store_above[c] = h;
        tap1 = tap0;
        tap0 = above;
        left_sample = h;
        col_cnt = c + 1;
        if (col_cnt >= len)
        begin
            col_cnt = 0;
            row_cnt = r + 1;
            if (row_cnt >= len)
                row_cnt = 0;
        end
    endtask

    task automatic write_reg(input logic [0:0] idx, input logic [31:0] value);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (idx == REG_ROW_LENGTH)
            row_len_reg = value & 32'h7ff;
        else
            span_reg = value & 32'hffff;
    endtask

    task automatic wait_drained();
        while (pending_normals.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    task automatic send_sample(input logic [15:0] h, input logic fs,
                               input bit typed, input normal_t want);
        bit      hit;
        normal_t res;
        height <= h;
        frame_start <= fs;
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predict_normal(h, fs, hit, res);
        if (hit)
            pending_normals.push_back(typed ? want : res);
        if (!quiet && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
    endtask

    function automatic logic [15:0] rand_height(logic [15:0] base);
        case ($urandom_range(0, 3))
            0: return 16'($urandom);
            1: return $urandom_range(0, 1) ? 16'hffff : 16'h0000;
            default: return base + 16'($urandom_range(0, 255)) - 16'd128;
        endcase
    endfunction

    task automatic add_row(input logic [15:0] h, input logic fs, input bit typed,
                           input normal_t want);
        sample_row_t t;
        t.h = h;
        t.fs = fs;
        t.typed = typed;
        t.want = want;
        directed_rows.push_back(t);
    endtask

    task automatic send_grid(input int count, input bit fs_first);
        logic [15:0] base;
        base = 16'($urandom);
        for (int i = 0; i < count; i++)
            send_sample(rand_height(base), fs_first && i == 0, 1'b0, '0);
    endtask

    initial
    begin
        logic [15:0] g2 [0:8];
        logic [15:0] g3 [0:8];
        int          sent;
        int          cnt;
        int          len;
        int          eff;
        int          span_pick;
        for (int i = 0; i < 1024; i++)
        begin
            store_above[i] = '0;
            store_two_up[i] = '0;
        end
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        repeat (3) @(posedge clk);

        // Row length below range clamps to three; zero span acts as one.
        write_reg(REG_ROW_LENGTH, 32'd0);
        write_reg(REG_GRID_SPAN, 32'd0);
        for (int i = 0; i < 9; i++)
            add_row(16'hffff, i == 0, i == 8, '{16'sd0, 15'd32767, 16'sd0, 10'd1, 10'd1});
        g2 = '{16'h0, 16'h0, 16'h0, 16'h0, 16'h1234, 16'hffff, 16'h0, 16'h0, 16'h0};
        for (int i = 0; i < 9; i++)
            add_row(g2[i], i == 0, i == 8, '{16'sd0, 15'd1, -16'sd32768, 10'd1, 10'd1});
        // A frame start in the middle of a row restarts the grid.
        add_row(16'h5555, 1'b1, 1'b0, '0);
        add_row(16'haaaa, 1'b0, 1'b0, '0);
        g3 = '{16'h0, 16'hffff, 16'h0, 16'h7, 16'h7, 16'h7, 16'h0, 16'h0, 16'h0};
        for (int i = 0; i < 9; i++)
            add_row(g3[i], i == 0, i == 8, '{16'sd32767, 15'd1, 16'sd0, 10'd1, 10'd1});
        foreach (directed_rows[i])
            send_sample(directed_rows[i].h, directed_rows[i].fs,
                        directed_rows[i].typed, directed_rows[i].want);
        in_valid <= 1'b0;
        wait_drained();

        sent = 0;
        while (sent < 1570)
        begin
            len = $urandom_range(0, 7) == 0 ? $urandom_range(0, 2) : $urandom_range(3, 12);
            eff = len < 3 ? 3 : len;
            span_pick = $urandom_range(0, 5);
            write_reg(REG_ROW_LENGTH, len);
            write_reg(REG_GRID_SPAN, span_pick == 0 ? 0 :
                      span_pick == 1 ? 65535 :
                      span_pick == 2 ? $urandom_range(1, 64) : $urandom_range(0, 65535));
            for (int gidx = 0; gidx < 3 && sent < 1570; gidx++)
            begin
                if ($urandom_range(0, 7) == 0)
                begin
                    cnt = $urandom_range(1, eff * eff - 1);
                    send_grid(cnt, 1'b1);
                end
                else
                begin
                    cnt = eff * eff;
                    send_grid(cnt, gidx == 0 || $urandom_range(0, 1));
                end
                sent += cnt;
                if (sent > 1400)
                    quiet = 1'b1;
            end
            in_valid <= 1'b0;
            wait_drained();
        end

        for (int k = 0; k < 100000 && pending_normals.size() != 0; k++)
            @(posedge clk);
        repeat (200) @(posedge clk);
        if (!failed && pending_normals.size() == 0)
            $display("heightmap_normal_stencil_tb OK");
        else
            $display("heightmap_normal_stencil_tb NOT OK");
        $finish;
    end

    initial
    begin
        bit held;
        held = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (!held && beats_seen >= 10)
            begin
                held = 1'b1;
                out_ready <= 1'b0;
                for (int k = 0; k < 600; k++)
                    @(posedge clk);
            end
            if (quiet || $urandom_range(0, 2) != 0)
            begin
                out_ready <= 1'b1;
                repeat ($urandom_range(1, 30)) @(posedge clk);
            end
            else
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        normal_t want;
        if (rst_n && out_valid && out_ready)
        begin
            beats_seen <= beats_seen + 1;
            if (pending_normals.size() == 0)
            begin
                $display("%0t: unexpected beat, actual %h %h %h %0d %0d", $time,
                         normal_x, normal_y, normal_z, center_row, center_col);
                failed = 1'b1;
            end
            else
            begin
                want = pending_normals.pop_front();
                if (normal_x !== want.nx)
                begin
                    $display("%0t: normal_x expected %0d actual %0d", $time, want.nx, normal_x);
                    failed = 1'b1;
                end
                if (normal_y !== want.ny)
                begin
                    $display("%0t: normal_y expected %0d actual %0d", $time, want.ny, normal_y);
                    failed = 1'b1;
                end
                if (normal_z !== want.nz)
                begin
                    $display("%0t: normal_z expected %0d actual %0d", $time, want.nz, normal_z);
                    failed = 1'b1;
                end
                if (center_row !== want.row)
                begin
                    $display("%0t: center_row expected %0d actual %0d", $time, want.row,
                             center_row);
                    failed = 1'b1;
                end
                if (center_col !== want.col)
                begin
                    $display("%0t: center_col expected %0d actual %0d", $time, want.col,
                             center_col);
                    failed = 1'b1;
                end
            end
        end
    end

    initial
    begin
        #50000000;
        $display("heightmap_normal_stencil_tb NOT OK");
        $finish;
    end

endmodule
